FILE: src/bspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspd_pkg: shared types and constants of the button press detector
// Word formats of both channels, the per-lane result and register indexes.
// ----------------------------------------------------------------------------
package bspd_pkg;

	localparam int unsigned FIELD_BITS = 4;
	localparam int unsigned STAMP_BITS = 32;
	localparam int unsigned THRESH_BITS = 16;
	localparam int unsigned SETTLE_BITS = 4;
	localparam int unsigned CFG_ADDR_BITS = 2;
	localparam int unsigned CFG_DATA_BITS = 16;

	localparam int unsigned BTN_PREV = 0;
	localparam int unsigned BTN_NEXT = 1;
	localparam int unsigned BTN_HOME = 3;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_ENABLE_MASK   = 2'd0,
		CFG_LONG_PRESS_MS = 2'd1,
		CFG_SETTLE_SCANS  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] pin_levels;
		logic [STAMP_BITS-1:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] short_mask;
		logic [FIELD_BITS-1:0] long_mask;
		logic                  page_prev;
		logic                  page_next;
		logic                  home_signal;
		logic [FIELD_BITS-1:0] held_mask;
	} out_word_t;

	typedef struct packed {
		logic short_hit;
		logic long_hit;
		logic held;
	} lane_res_t;

endpackage

FILE: src/bspd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspd_lane: press tracker for one button
// Holds the pressed flag, settle countdown, press time and fired flag of one
// button and classifies each scan as short press, long press or neither.
// ----------------------------------------------------------------------------
module bspd_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic                                 enable,
	input  logic                                 pin_level,
	input  logic [bspd_pkg::STAMP_BITS-1:0]      now_ms,
	input  logic [bspd_pkg::THRESH_BITS-1:0]     long_press_ms,
	input  logic [bspd_pkg::SETTLE_BITS-1:0]     settle_scans,
	output bspd_pkg::lane_res_t                  res
);
	import bspd_pkg::*;

	logic                   held_q;
	logic                   fired_q;
	logic [SETTLE_BITS-1:0] count_q;
	logic [STAMP_BITS-1:0]  stamp_q;

	logic                   held_d;
	logic                   fired_d;
	logic [SETTLE_BITS-1:0] count_d;
	logic [STAMP_BITS-1:0]  stamp_d;
	logic [SETTLE_BITS-1:0] count_dec;
	logic [STAMP_BITS-1:0]  diff;
	logic                   is_long;
	logic                   pressed;

	assign pressed   = !pin_level;
	assign diff      = now_ms - stamp_q;
	// The held time is read as signed: a negative difference is never long.
	assign is_long   = !diff[STAMP_BITS-1] &&
		(diff[STAMP_BITS-2:0] >= {{(STAMP_BITS-1-THRESH_BITS){1'b0}}, long_press_ms});
	assign count_dec = (count_q != '0) ? count_q - 1'b1 : count_q;

	always_comb begin
		held_d        = held_q;
		fired_d       = fired_q;
		count_d       = count_q;
		stamp_d       = stamp_q;
		res.short_hit = 1'b0;
		res.long_hit  = 1'b0;
		if (enable) begin
			if (pressed && !held_q) begin
				held_d  = 1'b1;
				fired_d = 1'b0;
				count_d = settle_scans;
				stamp_d = now_ms;
			end else if (pressed) begin
				count_d = count_dec;
				if (count_dec == '0 && !fired_q && is_long) begin
					res.long_hit = 1'b1;
					fired_d      = 1'b1;
				end
			end else if (held_q) begin
				held_d        = 1'b0;
				count_d       = '0;
				fired_d       = 1'b0;
				res.short_hit = !fired_q && !is_long;
			end
		end
		res.held = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			fired_q <= 1'b0;
			count_q <= '0;
			stamp_q <= '0;
		end else if (accept) begin
			held_q  <= held_d;
			fired_q <= fired_d;
			count_q <= count_d;
			stamp_q <= stamp_d;
		end
	end

endmodule

FILE: src/bspd_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspd_merge: lane merge and output register
// Gathers the lane results into one result word, derives the page and home
// requests and holds the word until the consumer takes it.
// ----------------------------------------------------------------------------
module bspd_merge #(
	parameter int unsigned LANES = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  bspd_pkg::lane_res_t [LANES-1:0]      lane_res,
	output logic                                 in_ready,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bspd_pkg::out_word_t                  out_data
);
	import bspd_pkg::*;

	logic [FIELD_BITS-1:0] short_m;
	logic [FIELD_BITS-1:0] long_m;
	logic [FIELD_BITS-1:0] held_m;
	out_word_t             word_d;
	out_word_t             word_q;
	logic                  valid_q;

	for (genvar i = 0; i < FIELD_BITS; i++) begin : g_bits
		if (i < LANES) begin : g_live
			assign short_m[i] = lane_res[i].short_hit;
			assign long_m[i]  = lane_res[i].long_hit;
			assign held_m[i]  = lane_res[i].held;
		end else begin : g_none
			assign short_m[i] = 1'b0;
			assign long_m[i]  = 1'b0;
			assign held_m[i]  = 1'b0;
		end
	end

	always_comb begin
		word_d.short_mask  = short_m;
		word_d.long_mask   = long_m;
		word_d.page_prev   = short_m[BTN_PREV];
		word_d.page_next   = short_m[BTN_NEXT];
		word_d.home_signal = long_m[BTN_HOME];
		word_d.held_mask   = held_m;
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= word_d;
		end
	end

`ifndef SYNTHESIS
	a_no_short_and_long: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((word_q.short_mask & word_q.long_mask) == '0))
		else $error("short and long press on the same button in one word");
	a_long_is_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((word_q.long_mask & ~word_q.held_mask) == '0))
		else $error("long press reported on a released button");
	a_short_is_released: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((word_q.short_mask & word_q.held_mask) == '0))
		else $error("short press reported on a held button");
	a_word_taken: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_q)
		else $error("accepted scan produced no result word");
`endif

endmodule

FILE: src/button_short_long_press_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_short_long_press_detector_top: four-button short/long press detector
// Channel  Direction  Handshake               Word
// in       input      in_valid / in_ready     pin levels and time in ms
// out      output     out_valid / out_ready   press masks and requests
// cfg      input      cfg_we                  register index and data
// One scan word is accepted per cycle while in_ready is high; its result word
// is registered and shown the next cycle. in_ready is low only while a result
// word waits and out_ready is low. Each button has its own lane; the lanes
// update together. Reset clears all button state and loads register defaults.
// ----------------------------------------------------------------------------
module button_short_long_press_detector_top #(
	parameter int unsigned NUM_BUTTONS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bspd_pkg::in_word_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bspd_pkg::out_word_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [bspd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [bspd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import bspd_pkg::*;

	// Buttons above the field width have no enable bit and never change.
	localparam int unsigned LANES = (NUM_BUTTONS < FIELD_BITS) ? NUM_BUTTONS : FIELD_BITS;

	logic [FIELD_BITS-1:0]  enable_mask_q;
	logic [THRESH_BITS-1:0] long_press_ms_q;
	logic [SETTLE_BITS-1:0] settle_scans_q;
	logic                   accept;
	lane_res_t [LANES-1:0]  lane_res;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q   <= 4'd15;
			long_press_ms_q <= 16'd1000;
			settle_scans_q  <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_ENABLE_MASK:   enable_mask_q   <= cfg_data[FIELD_BITS-1:0];
				CFG_LONG_PRESS_MS: long_press_ms_q <= cfg_data[THRESH_BITS-1:0];
				CFG_SETTLE_SCANS:  settle_scans_q  <= cfg_data[SETTLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		bspd_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.accept        (accept),
			.enable        (enable_mask_q[i]),
			.pin_level     (in_data.pin_levels[i]),
			.now_ms        (in_data.now_ms),
			.long_press_ms (long_press_ms_q),
			.settle_scans  (settle_scans_q),
			.res           (lane_res[i])
		);
	end

	bspd_merge #(
		.LANES (LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.lane_res  (lane_res),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: tb/bspd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspd_checker: scoreboard for the button press detector
// Watches the scan, result and register channels, keeps its own copy of the
// per-button press state, predicts the result word of every accepted scan
// word and compares each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module bspd_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  bspd_pkg::in_word_t                 in_data,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  bspd_pkg::out_word_t                out_data,
	input  logic                               cfg_we,
	input  logic [bspd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [bspd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output int                                 fail_count,
	output int                                 pending
);

	import bspd_pkg::*;

	logic [FIELD_BITS-1:0]  en_mask;
	logic [THRESH_BITS-1:0] long_ms;
	logic [SETTLE_BITS-1:0] settle_cfg;

	logic                   btn_held [FIELD_BITS];
	logic [SETTLE_BITS-1:0] btn_settle [FIELD_BITS];
	logic [STAMP_BITS-1:0]  btn_stamp [FIELD_BITS];
	logic                   btn_fired [FIELD_BITS];

	out_word_t due_words [$];

	function automatic out_word_t detect_presses(in_word_t w);
		out_word_t r;
		logic [STAMP_BITS-1:0] dt;
		logic pressed;
		logic reached;
		r = '0;
		for (int i = 0; i < FIELD_BITS; i++) begin
			pressed = !w.pin_levels[i];
			dt = w.now_ms - btn_stamp[i];
			// A wrapped difference with the top bit set is a negative held time.
			reached = !dt[STAMP_BITS-1] && (dt >= {{(STAMP_BITS-THRESH_BITS){1'b0}}, long_ms});
			if (en_mask[i]) begin
				if (pressed) begin
					if (!btn_held[i]) begin
						btn_settle[i] = settle_cfg;
						btn_stamp[i] = w.now_ms;
						btn_held[i] = 1'b1;
						btn_fired[i] = 1'b0;
					end else begin
						if (btn_settle[i] != 0)
							btn_settle[i] = btn_settle[i] - 1'b1;
						if (btn_settle[i] == 0 && !btn_fired[i] && reached) begin
							r.long_mask[i] = 1'b1;
							btn_fired[i] = 1'b1;
						end
					end
				end else if (btn_held[i]) begin
					btn_held[i] = 1'b0;
					btn_settle[i] = '0;
					if (!btn_fired[i] && !reached)
						r.short_mask[i] = 1'b1;
					btn_fired[i] = 1'b0;
				end
			end
			r.held_mask[i] = btn_held[i];
		end
		r.page_prev = r.short_mask[BTN_PREV];
		r.page_next = r.short_mask[BTN_NEXT];
		r.home_signal = r.long_mask[BTN_HOME];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			en_mask = 4'hF;
			long_ms = 16'd1000;
			settle_cfg = 4'd2;
			for (int i = 0; i < FIELD_BITS; i++) begin
				btn_held[i] = 1'b0;
				btn_settle[i] = '0;
				btn_stamp[i] = '0;
				btn_fired[i] = 1'b0;
			end
			due_words.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					CFG_ENABLE_MASK: en_mask = cfg_data[FIELD_BITS-1:0];
					CFG_LONG_PRESS_MS: long_ms = cfg_data[THRESH_BITS-1:0];
					CFG_SETTLE_SCANS: settle_cfg = cfg_data[SETTLE_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				due_words.push_back(detect_presses(in_data));
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result word with no scan word waiting: %h",
							$realtime, out_data);
					fail_count++;
				end else begin
					want = due_words.pop_front();
					if (out_data.short_mask !== want.short_mask ||
						out_data.long_mask !== want.long_mask ||
						out_data.page_prev !== want.page_prev ||
						out_data.page_next !== want.page_next ||
						out_data.home_signal !== want.home_signal ||
						out_data.held_mask !== want.held_mask) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch expected short=%h long=%h prev=%b next=%b home=%b held=%h",
								$realtime, want.short_mask, want.long_mask, want.page_prev,
								want.page_next, want.home_signal, want.held_mask);
							$display("%0t: mismatch actual   short=%h long=%h prev=%b next=%b home=%b held=%h",
								$realtime, out_data.short_mask, out_data.long_mask,
								out_data.page_prev, out_data.page_next, out_data.home_signal,
								out_data.held_mask);
						end
						fail_count++;
					end
				end
			end
		end
		pending = due_words.size();
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the button press detector
// Drives scan words of button levels and time through a directed sequence of
// press, hold and release cases, then through register settings with random
// press sequences, while the result side stalls at random. A separate checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

	import bspd_pkg::*;

	localparam int QUIET_LIMIT = 1000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;
	logic cfg_we;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	int fails;
	int open_words;
	logic in_took;
	int quiet_cycles;
	int idle_pct = 13;
	int stall_asks = 0;
	int stall_served = 0;

	int cur_long = 1000;
	int cur_settle = 2;
	logic [STAMP_BITS-1:0] clock_ms = '0;
	bit btn_down [FIELD_BITS];
	int btn_left [FIELD_BITS];

	button_short_long_press_detector_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	bspd_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.fail_count(fails),
		.pending(open_words)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_took <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			in_took <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_served < stall_asks) begin
				out_ready = 1'b0;
				repeat (40) @(negedge clk);
				stall_served++;
			end else begin
				out_ready = ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	task automatic push_scan(input logic [FIELD_BITS-1:0] pins, input logic [STAMP_BITS-1:0] t);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.pin_levels = pins;
		in_data.now_ms = t;
		do @(negedge clk); while (!in_took);
	endtask

	task automatic wait_all_out();
		in_valid = 1'b0;
		while (open_words != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] v);
		cfg_we = 1'b1;
		cfg_addr = r;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_scan();
		logic [FIELD_BITS-1:0] pins;
		for (int i = 0; i < FIELD_BITS; i++) begin
			if (btn_left[i] == 0) begin
				btn_down[i] = !btn_down[i];
				btn_left[i] = btn_down[i] ? $urandom_range(1, cur_settle + 8) : $urandom_range(1, 4);
			end
			btn_left[i]--;
			pins[i] = !btn_down[i];
		end
		if ($urandom_range(0, 11) == 0)
			pins = FIELD_BITS'($urandom_range(0, 15));
		if ($urandom_range(0, 39) == 0)
			clock_ms += $urandom;
		else
			clock_ms += $urandom_range(0, cur_long / 3 + 20);
		push_scan(pins, clock_ms);
	endtask

	task automatic run_phase(input int en, input int lng, input int stl, input int count,
		input bit no_idle, input bit hold_off);
		wait_all_out();
		write_reg(CFG_ENABLE_MASK, CFG_DATA_BITS'(en));
		write_reg(CFG_LONG_PRESS_MS, CFG_DATA_BITS'(lng));
		write_reg(CFG_SETTLE_SCANS, CFG_DATA_BITS'(stl));
		cur_long = lng;
		cur_settle = stl;
		idle_pct = no_idle ? 0 : 13;
		for (int k = 0; k < count; k++) begin
			if (hold_off && k == 40)
				stall_asks++;
			random_scan();
		end
		idle_pct = 13;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_scan(4'hF, 32'd0);
		push_scan(4'hE, 32'd100);
		push_scan(4'hE, 32'd200);
		push_scan(4'hE, 32'd300);
		push_scan(4'hF, 32'd400);
		push_scan(4'hD, 32'd1000);
		push_scan(4'hF, 32'd1500);
		push_scan(4'h7, 32'd2000);
		push_scan(4'h7, 32'd2100);
		push_scan(4'h7, 32'd3100);
		push_scan(4'h7, 32'd9000);
		push_scan(4'hF, 32'd9100);
		push_scan(4'hB, 32'd4000);
		push_scan(4'hB, 32'd5000);
		push_scan(4'hB, 32'd5001);
		push_scan(4'hF, 32'd5002);
		push_scan(4'h0, 32'hFFFF_FF00);
		push_scan(4'h0, 32'hFFFF_FFFF);
		push_scan(4'h0, 32'h0000_0400);
		push_scan(4'hF, 32'hFFFF_FFFE);
		push_scan(4'h0, 32'h0000_0010);
		push_scan(4'hF, 32'h9000_0000);
		wait_all_out();
		write_reg(CFG_SETTLE_SCANS, 16'd0);
		write_reg(CFG_LONG_PRESS_MS, 16'd0);
		push_scan(4'h0, 32'd7);
		push_scan(4'h0, 32'd7);
		wait_all_out();
		write_reg(CFG_ENABLE_MASK, 16'h0006);
		push_scan(4'hF, 32'd8);

		run_phase(15, 1000, 2, 220, 1'b0, 1'b0);
		run_phase(15, 0, 0, 180, 1'b0, 1'b0);
		run_phase(15, 65535, 15, 200, 1'b0, 1'b1);
		run_phase(4'hA, 300, 1, 180, 1'b0, 1'b0);
		run_phase(0, 700, 5, 60, 1'b0, 1'b0);
		run_phase(15, 400, 3, 260, 1'b1, 1'b0);
		for (int p = 0; p < 3; p++)
			run_phase($urandom_range(0, 15), $urandom_range(0, 5000), $urandom_range(0, 15),
				200, 1'b0, 1'b0);

		wait_all_out();
		repeat (10) @(negedge clk);
		if (fails == 0 && open_words == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
src/bspd_pkg.sv
src/bspd_lane.sv
src/bspd_merge.sv
src/button_short_long_press_detector_top.sv
tb/bspd_checker.sv
tb/testbench.sv
